[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the queue RTL modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property, checked at every rising edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// condition that must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[hw/rtl/mbeq_pkg.sv]
// ----------------------------------------------------------------------------
// mbeq_pkg
// Shared opcodes, constants and controller command type for the mouse
// button event queue
// ----------------------------------------------------------------------------
package mbeq_pkg;

	// operation codes carried by each word
	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_POLL   = 2'd1;
	localparam logic [1:0] OP_OPEN   = 2'd2;
	localparam logic [1:0] OP_CLOSE  = 2'd3;

	// header bits 7..3 of a valid mouse packet
	localparam logic [4:0] HDR_TAG = 5'b00001;

	// default ring size, one slot always left empty
	localparam int DEFAULT_QUEUE_DEPTH = 16;

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // capture the incoming word
		logic exec;     // apply the operation to queue state
		logic respond;  // present the result for one cycle
	} ctrl_cmd_t;

endpackage

[hw/rtl/mbeq_ctrl.sv]
// ----------------------------------------------------------------------------
// mbeq_ctrl
// Sequencer for the event queue: capture, execute, respond
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbeq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output mbeq_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       take;

	// a new word may enter while the previous result is being shown
	assign busy = (state_q == ST_EXEC);
	assign take = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = take ? ST_EXEC : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands to the datapath
	assign cmd.load    = take;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.respond = (state_q == ST_RESP);

	`ASSERT_PROP(a_take_then_exec, clk, arst_n, take |=> cmd.exec,
		"accepted word not executed next cycle")
	`ASSERT_PROP(a_exec_then_resp, clk, arst_n, cmd.exec |=> cmd.respond,
		"execute not followed by response")
	`ASSERT_PROP(a_resp_after_exec, clk, arst_n, cmd.respond |-> $past(cmd.exec),
		"response without preceding execute")
	`ASSERT_NEVER(a_load_during_exec, clk, arst_n, cmd.load && cmd.exec,
		"word captured while executing")

endmodule

[hw/rtl/mbeq_dp.sv]
// ----------------------------------------------------------------------------
// mbeq_dp
// Queue datapath: pointers, open flag, button state, event store, result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mbeq_dp #(
	parameter int QUEUE_DEPTH = mbeq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mbeq_pkg::ctrl_cmd_t cmd,
	input  logic [1:0]          opcode,
	input  logic [7:0]          header_byte,
	output logic                done,
	output logic                ok,
	output logic                event_kind,
	output logic [2:0]          event_buttons
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	// captured word
	logic [1:0]       op_q;
	logic [7:0]       hdr_q;

	// queue state
	logic             open_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [2:0]       last_btn_q;
	logic [3:0]       store_q [QUEUE_DEPTH];

	// result
	logic             ok_q;
	logic             hit_q;
	logic [3:0]       rd_data_q;

	// next-state values
	logic [PTR_W-1:0] rd_next;
	logic [PTR_W-1:0] wr_next;
	logic             empty;
	logic             full;
	logic             tag_ok;
	logic [2:0]       new_btn;
	logic             is_release;
	logic [3:0]       entry;
	logic             do_open;
	logic             do_close;
	logic             do_pop;
	logic             do_push;

	// capture the word at accept
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			hdr_q <= header_byte;
		end
	end

	// ring arithmetic and packet decode
	always_comb begin
		rd_next    = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
		wr_next    = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
		empty      = (rd_ptr_q == wr_ptr_q);
		full       = (wr_next == rd_ptr_q);
		tag_ok     = (hdr_q[7:3] == mbeq_pkg::HDR_TAG);
		new_btn    = hdr_q[2:0];
		is_release = (new_btn < last_btn_q);
		entry      = is_release ? {1'b1, 3'(last_btn_q - new_btn)}
		                        : {1'b0, 3'(new_btn - last_btn_q)};
		do_open    = 1'b0;
		do_close   = 1'b0;
		do_pop     = 1'b0;
		do_push    = 1'b0;
		if (cmd.exec) begin
			case (op_q)
				mbeq_pkg::OP_OPEN: begin
					do_open = !open_q;
				end
				mbeq_pkg::OP_CLOSE: begin
					do_close = 1'b1;
				end
				mbeq_pkg::OP_POLL: begin
					do_pop = open_q && !empty;
				end
				mbeq_pkg::OP_PACKET: begin
					do_push = open_q && !full && tag_ok;
				end
				default: begin
					do_close = 1'b0;
				end
			endcase
		end
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			last_btn_q <= '0;
			ok_q       <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			if (do_open) begin
				open_q   <= 1'b1;
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end
			if (do_close) open_q <= 1'b0;
			if (do_pop) rd_ptr_q <= rd_next;
			if (do_push) begin
				wr_ptr_q   <= wr_next;
				last_btn_q <= new_btn;
			end
			if (cmd.exec) begin
				ok_q  <= do_open || do_pop || do_push;
				hit_q <= do_pop;
			end
		end
	end

	// event store, registered read at the read pointer
	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_ptr_q] <= entry;
		if (cmd.exec) rd_data_q <= store_q[rd_ptr_q];
	end

	// result word, event fields zero unless an event was popped
	assign done          = cmd.respond;
	assign ok            = ok_q;
	assign event_kind    = hit_q && rd_data_q[3];
	assign event_buttons = hit_q ? rd_data_q[2:0] : 3'b000;

	`ASSERT_PROP(a_rd_in_range, clk, arst_n, rd_ptr_q <= PTR_LAST,
		"read pointer beyond ring")
	`ASSERT_PROP(a_wr_in_range, clk, arst_n, wr_ptr_q <= PTR_LAST,
		"write pointer beyond ring")
	`ASSERT_PROP(a_close_clears, clk, arst_n, do_close |=> !open_q,
		"close did not clear open flag")
	`ASSERT_PROP(a_hit_is_ok, clk, arst_n, hit_q |-> ok_q,
		"popped event without ok")

endmodule

[hw/rtl/mouse_button_event_queue.sv]
// ----------------------------------------------------------------------------
// mouse_button_event_queue
// Ring queue of mouse button press and release events with open, close,
// packet and poll operations
// ----------------------------------------------------------------------------
// result strobe done is raised in the respond state, which follows the execute state
// the execute state does the registered read of the event store; a new word can be
//   accepted while the previous result is shown, and busy is high only during execute
// reset: arst_n clears the open flag, both pointers, button state and control;
//   the event store is not cleared and needs no clearing pass
// results cannot be held off: each is on the ports for exactly one cycle

module mouse_button_event_queue #(
	parameter int QUEUE_DEPTH = mbeq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [7:0] header_byte,
	output logic       done,
	output logic       ok,
	output logic       event_kind,
	output logic [2:0] event_buttons
);

	mbeq_pkg::ctrl_cmd_t cmd;

	// sequencer
	mbeq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// queue state and result
	mbeq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.header_byte   (header_byte),
		.done          (done),
		.ok            (ok),
		.event_kind    (event_kind),
		.event_buttons (event_buttons)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mouse button event queue. A queue of words is
// filled up front and fed to the block through start/busy with random gaps.
// Every accepted word runs through a behavioral ring queue model, and each
// done strobe is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH = mbeq_pkg::DEFAULT_QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int IDLE_LIMIT = 200;
	localparam int RANDOM_WORDS = 370;

	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct {
		logic [1:0] op;
		logic [7:0] hdr;
	} queue_word_t;

	typedef struct {
		logic       ok;
		logic       kind;
		logic [2:0] buttons;
	} queue_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] opcode = mbeq_pkg::OP_CLOSE;
	logic [7:0] header_byte = 8'h00;
	logic       busy;
	logic       done;
	logic       ok;
	logic       event_kind;
	logic [2:0] event_buttons;

	mouse_button_event_queue #(
		.QUEUE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.header_byte(header_byte),
		.done(done),
		.ok(ok),
		.event_kind(event_kind),
		.event_buttons(event_buttons)
	);

	always #5 clk = ~clk;

	// stimulus and expected results
	queue_word_t   pending_words[$];
	queue_result_t expected_results[$];

	// shadow of the block's queue state
	logic       shadow_open = 1'b0;
	ptr_t       shadow_rd = '0;
	ptr_t       shadow_wr = '0;
	logic [2:0] shadow_buttons = 3'd0;
	logic [3:0] shadow_store[DEPTH];

	int mismatch_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int events_popped = 0;
	int releases_popped = 0;
	int full_refusals = 0;
	int good_opens = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic add_word(input logic [1:0] op, input logic [7:0] hdr);
		queue_word_t w;
		w.op = op;
		w.hdr = hdr;
		pending_words.push_back(w);
	endtask

	task automatic add_packet(input logic [2:0] btn);
		add_word(mbeq_pkg::OP_PACKET, {mbeq_pkg::HDR_TAG, btn});
	endtask

	// header byte whose tag bits are anything but the packet tag
	function automatic logic [7:0] bad_header();
		logic [7:0] b;
		b = 8'($urandom);
		while (b[7:3] == mbeq_pkg::HDR_TAG)
			b = 8'($urandom);
		return b;
	endfunction

	// apply one accepted word to the shadow queue and queue its result
	task automatic predict_queue_step(input logic [1:0] op, input logic [7:0] hdr);
		queue_result_t r;
		ptr_t          nxt;
		logic [2:0]    new_btn;
		r.ok = 1'b0;
		r.kind = EV_PRESS;
		r.buttons = 3'd0;
		nxt = shadow_wr + 1'b1;
		new_btn = hdr[2:0];
		case (op)
		mbeq_pkg::OP_OPEN: begin
			if (!shadow_open) begin
				shadow_rd = '0;
				shadow_wr = '0;
				shadow_open = 1'b1;
				r.ok = 1'b1;
				good_opens++;
			end
		end
		mbeq_pkg::OP_CLOSE: begin
			shadow_open = 1'b0;
		end
		mbeq_pkg::OP_POLL: begin
			if (shadow_open && shadow_rd != shadow_wr) begin
				{r.kind, r.buttons} = shadow_store[shadow_rd];
				shadow_rd = shadow_rd + 1'b1;
				r.ok = 1'b1;
				events_popped++;
				if (r.kind == EV_RELEASE)
					releases_popped++;
			end
		end
		mbeq_pkg::OP_PACKET: begin
			if (shadow_open && hdr[7:3] == mbeq_pkg::HDR_TAG && nxt == shadow_rd)
				full_refusals++;
			if (shadow_open && hdr[7:3] == mbeq_pkg::HDR_TAG && nxt != shadow_rd) begin
				if (new_btn < shadow_buttons)
					shadow_store[shadow_wr] = {EV_RELEASE, 3'(shadow_buttons - new_btn)};
				else
					shadow_store[shadow_wr] = {EV_PRESS, 3'(new_btn - shadow_buttons)};
				shadow_buttons = new_btn;
				shadow_wr = nxt;
				r.ok = 1'b1;
			end
		end
		default: begin
			r.ok = 1'b0;
		end
		endcase
		expected_results.push_back(r);
	endtask

	// driver: present queued words, hold each until accepted
	always @(posedge clk) begin
		queue_word_t w;
		logic        take;
		if (arst_n) begin
			take = start && !busy;
			if (take) begin
				predict_queue_step(opcode, header_byte);
				words_sent++;
			end
			if (!start || take) begin
				if (gap_left != 0) begin
					start <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					opcode <= w.op;
					header_byte <= w.hdr;
					start <= 1'b1;
					// switch now and then between random gaps and back-to-back words
					if ($urandom_range(0, 31) == 0)
						steady = !steady;
					gap_left <= steady ? 0 : $urandom_range(0, 15);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result word, watchdog on stalled traffic
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result ok=%0b kind=%0b buttons=%0d",
						ok, event_kind, event_buttons));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (ok !== want.ok)
						report_mismatch($sformatf("ok got %0b want %0b", ok, want.ok));
					if (event_kind !== want.kind)
						report_mismatch($sformatf("event_kind got %0b want %0b",
							event_kind, want.kind));
					if (event_buttons !== want.buttons)
						report_mismatch($sformatf("event_buttons got %0d want %0d",
							event_buttons, want.buttons));
				end
			end
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] watchdog: no traffic for %0d cycles", $time, IDLE_LIMIT);
				$display("tb_top NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// reset, stimulus and end of run
	initial begin
		int r;
		int n;
		int added;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: closed queue, double open, bad tags, press and release extremes
		add_word(mbeq_pkg::OP_CLOSE, 8'h00);
		add_word(mbeq_pkg::OP_POLL, 8'hFF);
		add_packet(3'd7);
		add_word(mbeq_pkg::OP_OPEN, 8'h00);
		add_word(mbeq_pkg::OP_OPEN, 8'hFF);
		add_word(mbeq_pkg::OP_POLL, 8'h00);
		add_word(mbeq_pkg::OP_PACKET, 8'hFF);
		add_word(mbeq_pkg::OP_PACKET, 8'h00);
		add_word(mbeq_pkg::OP_PACKET, 8'hF7);
		add_packet(3'd0);
		add_packet(3'd7);
		add_packet(3'd0);
		add_packet(3'd5);
		add_packet(3'd1);
		repeat (6) add_word(mbeq_pkg::OP_POLL, 8'h00);
		add_word(mbeq_pkg::OP_CLOSE, 8'h00);
		add_word(mbeq_pkg::OP_CLOSE, 8'h00);
		add_word(mbeq_pkg::OP_POLL, 8'h00);
		add_packet(3'd3);

		// random: mostly packet bursts and poll runs on an open queue
		added = 0;
		while (added < RANDOM_WORDS) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				if ($urandom_range(0, 3) == 0) begin
					add_word(mbeq_pkg::OP_OPEN, 8'($urandom));
					added++;
				end
				n = $urandom_range(4, 20);
				repeat (n) begin
					if ($urandom_range(0, 9) == 0)
						add_word(mbeq_pkg::OP_PACKET, bad_header());
					else
						add_packet(3'($urandom));
				end
				added += n;
			end else if (r < 75) begin
				n = $urandom_range(1, 20);
				repeat (n) add_word(mbeq_pkg::OP_POLL, 8'($urandom));
				added += n;
			end else if (r < 85) begin
				n = $urandom_range(1, 3);
				repeat (n) add_word(2'($urandom), 8'($urandom));
				added += n;
			end else if (r < 93) begin
				add_word(mbeq_pkg::OP_CLOSE, 8'($urandom));
				if ($urandom_range(0, 1) == 0)
					add_word(mbeq_pkg::OP_POLL, 8'($urandom));
				add_word(mbeq_pkg::OP_OPEN, 8'($urandom));
				added += 2;
			end else begin
				n = $urandom_range(4, 16);
				repeat (n) begin
					if ($urandom_range(0, 1) == 0)
						add_packet(3'($urandom));
					else
						add_word(mbeq_pkg::OP_POLL, 8'($urandom));
				end
				added += n;
			end
		end

		while (pending_words.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d words and %0d results: %0d events popped, %0d of them releases",
			words_sent, results_checked, events_popped, releases_popped);
		$display("%0d packets refused on a full ring, %0d opens accepted",
			full_refusals, good_opens);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
